// ===== src/dsq_pkg.sv =====
package dsq_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int CYLINDER_BITS_DEF = 16;
	localparam int TAG_BITS          = 8;

	localparam logic B_READ = 1'b1;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_LINK1,
		S_LINK2,
		S_POP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} res_ctl_t;

endpackage

// ===== src/dsq_ram.sv =====
module dsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/dsq_core.sv =====
module dsq_core #(
	parameter int QUEUE_DEPTH   = dsq_pkg::QUEUE_DEPTH_DEF,
	parameter int CYLINDER_BITS = dsq_pkg::CYLINDER_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic                               is_read,
	input  logic [CYLINDER_BITS-1:0]           cylinder,
	input  logic [dsq_pkg::TAG_BITS-1:0]       tag,
	output dsq_pkg::res_ctl_t                  res_ctl,
	input  logic                               res_ready,
	output logic [dsq_pkg::TAG_BITS-1:0]       res_tag,
	output logic                               res_is_read,
	output logic [CYLINDER_BITS-1:0]           res_cylinder,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   res_occupancy
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = dsq_pkg::TAG_BITS;
	localparam int DW = 1 + CYLINDER_BITS + TW;

	dsq_pkg::state_t  state_q, state_d;
	dsq_pkg::status_t status_q;

	logic                     cmd_q;
	logic                     rd_q;
	logic [CYLINDER_BITS-1:0] cyl_q;
	logic [TW-1:0]            tag_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] alloc_q;
	logic [CW-1:0] left_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] free_head_q;
	logic [PW-1:0] new_q;
	logic [PW-1:0] ptr_q;

	logic                     have_q;
	logic [PW-1:0]            cand_q;
	logic [CYLINDER_BITS-1:0] cand_cyl_q;
	logic [PW-1:0]            cand_next_q;

	logic [TW-1:0]            res_tag_q;
	logic                     res_rd_q;
	logic [CYLINDER_BITS-1:0] res_cyl_q;

	logic          d_we, l_we;
	logic [PW-1:0] d_waddr, l_waddr, d_raddr, l_raddr;
	logic [DW-1:0] d_wdata, d_rdata;
	logic [PW-1:0] l_wdata, l_rdata;

	logic                     e_rd;
	logic [CYLINDER_BITS-1:0] e_cyl;
	logic [TW-1:0]            e_tag;
	logic                     stop, skip, fits, take, scan_last;
	logic                     alloc_full;
	logic [PW-1:0]            new_slot;

	assign e_rd  = d_rdata[DW-1];
	assign e_cyl = d_rdata[TW +: CYLINDER_BITS];
	assign e_tag = d_rdata[TW-1:0];

	// seek order candidate rule for one queued entry
	assign stop      = rd_q && (e_rd != dsq_pkg::B_READ);
	assign skip      = !rd_q && (e_rd == dsq_pkg::B_READ);
	assign fits      = (e_cyl <= cyl_q) && (!have_q || (e_cyl >= cand_cyl_q));
	assign take      = stop ? !have_q : (!skip && fits);
	assign scan_last = stop || (left_q == CW'(1));

	assign alloc_full = (alloc_q == CW'(QUEUE_DEPTH));
	assign new_slot   = alloc_full ? free_head_q : alloc_q[PW-1:0];

	dsq_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	dsq_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		d_raddr  = head_q;
		l_raddr  = head_q;
		d_we     = 1'b0;
		d_waddr  = new_q;
		d_wdata  = {rd_q, cyl_q, tag_q};
		l_we     = 1'b0;
		l_waddr  = new_q;
		l_wdata  = cand_next_q;
		case (state_q)
			dsq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (command == dsq_pkg::CMD_INSERT) begin
					l_raddr = free_head_q;
				end
				if (in_valid) begin
					if (command == dsq_pkg::CMD_INSERT) begin
						state_d = (count_q == CW'(QUEUE_DEPTH)) ? dsq_pkg::S_RESP
							: dsq_pkg::S_PREP;
					end else begin
						state_d = (count_q == '0) ? dsq_pkg::S_RESP : dsq_pkg::S_POP;
					end
				end
			end
			dsq_pkg::S_PREP: begin
				if (count_q == '0) begin
					d_we    = 1'b1;
					d_waddr = new_slot;
					state_d = dsq_pkg::S_RESP;
				end else begin
					state_d = dsq_pkg::S_SCAN;
				end
			end
			dsq_pkg::S_SCAN: begin
				d_raddr = l_rdata;
				l_raddr = l_rdata;
				if (scan_last) begin
					state_d = dsq_pkg::S_LINK1;
				end
			end
			dsq_pkg::S_LINK1: begin
				d_we    = 1'b1;
				l_we    = 1'b1;
				state_d = dsq_pkg::S_LINK2;
			end
			dsq_pkg::S_LINK2: begin
				l_we    = 1'b1;
				l_waddr = have_q ? cand_q : tail_q;
				l_wdata = new_q;
				state_d = dsq_pkg::S_RESP;
			end
			dsq_pkg::S_POP: begin
				// freed head goes onto the free list
				l_we    = 1'b1;
				l_waddr = head_q;
				l_wdata = free_head_q;
				state_d = dsq_pkg::S_RESP;
			end
			dsq_pkg::S_RESP: begin
				if (res_ready) begin
					state_d = dsq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dsq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			alloc_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			free_head_q <= '0;
			have_q      <= 1'b0;
			left_q      <= '0;
		end else begin
			case (state_q)
				dsq_pkg::S_PREP: begin
					if (alloc_full) begin
						free_head_q <= l_rdata;
					end else begin
						alloc_q <= alloc_q + CW'(1);
					end
					if (count_q == '0) begin
						head_q  <= new_slot;
						tail_q  <= new_slot;
						count_q <= count_q + CW'(1);
					end else begin
						left_q <= count_q;
						have_q <= 1'b0;
					end
				end
				dsq_pkg::S_SCAN: begin
					left_q <= left_q - CW'(1);
					if (take) begin
						have_q <= 1'b1;
					end
				end
				dsq_pkg::S_LINK2: begin
					if (!have_q || (cand_q == tail_q)) begin
						tail_q <= new_q;
					end
					count_q <= count_q + CW'(1);
				end
				dsq_pkg::S_POP: begin
					head_q      <= l_rdata;
					free_head_q <= head_q;
					count_q     <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dsq_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd_q     <= command;
					rd_q      <= is_read;
					cyl_q     <= cylinder;
					tag_q     <= tag;
					res_tag_q <= '0;
					res_rd_q  <= 1'b0;
					res_cyl_q <= '0;
					if (command == dsq_pkg::CMD_INSERT) begin
						status_q <= (count_q == CW'(QUEUE_DEPTH)) ? dsq_pkg::ST_FULL
							: dsq_pkg::ST_DONE;
					end else begin
						status_q <= (count_q == '0) ? dsq_pkg::ST_EMPTY : dsq_pkg::ST_DONE;
					end
				end
			end
			dsq_pkg::S_PREP: begin
				new_q <= new_slot;
				ptr_q <= head_q;
			end
			dsq_pkg::S_SCAN: begin
				ptr_q <= l_rdata;
				if (take) begin
					cand_q      <= ptr_q;
					cand_cyl_q  <= e_cyl;
					cand_next_q <= l_rdata;
				end
			end
			dsq_pkg::S_POP: begin
				res_tag_q <= e_tag;
				res_rd_q  <= e_rd;
				res_cyl_q <= e_cyl;
			end
			default: begin
			end
		endcase
	end

	assign res_ctl.valid  = (state_q == dsq_pkg::S_RESP);
	assign res_ctl.status = status_q;
	assign res_tag        = res_tag_q;
	assign res_is_read    = res_rd_q;
	assign res_cylinder   = res_cyl_q;
	assign res_occupancy  = count_q;

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_alloc_cover: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q >= count_q)
		else $error("fill mark below queue count");
	a_scan_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsq_pkg::S_SCAN |-> left_q != '0)
		else $error("scan past end of queue");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsq_pkg::S_POP |=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not shrink queue");
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsq_pkg::S_SCAN |-> cmd_q == dsq_pkg::CMD_INSERT)
		else $error("scan on a remove transaction");
`endif

endmodule

// ===== src/disk_request_seek_sort_queue_top.sv =====
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// in       | in_valid/in_ready  | command, is_read, cylinder, tag
// out      | out_valid/out_ready| status, out_tag, out_is_read, out_cylinder, occupancy
//
// requests live in a linked list in two one-port-read rams (entry data, next links);
// insert walks the list from the head one entry per cycle, no walk on an empty queue;
// remove unlinks the head in the pop state; a refused transaction (full or empty)
// goes straight from idle to the response state
// reset clears counts and pointers only, the rams need no clearing pass
// a transaction is taken while the previous result still waits in the output register
module disk_request_seek_sort_queue_top #(
	parameter int QUEUE_DEPTH   = dsq_pkg::QUEUE_DEPTH_DEF,
	parameter int CYLINDER_BITS = dsq_pkg::CYLINDER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              command,
	input  logic                              is_read,
	input  logic [CYLINDER_BITS-1:0]          cylinder,
	input  logic [dsq_pkg::TAG_BITS-1:0]      tag,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [dsq_pkg::TAG_BITS-1:0]      out_tag,
	output logic                              out_is_read,
	output logic [CYLINDER_BITS-1:0]          out_cylinder,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]  occupancy
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	dsq_pkg::res_ctl_t                res_ctl;
	logic                             res_ready;
	logic [dsq_pkg::TAG_BITS-1:0]     res_tag;
	logic                             res_is_read;
	logic [CYLINDER_BITS-1:0]         res_cylinder;
	logic [CW-1:0]                    res_occupancy;

	logic                             out_valid_q;
	dsq_pkg::status_t                 status_q;
	logic [dsq_pkg::TAG_BITS-1:0]     tag_q;
	logic                             rd_q;
	logic [CYLINDER_BITS-1:0]         cyl_q;
	logic [CW-1:0]                    occ_q;

	dsq_core #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.CYLINDER_BITS (CYLINDER_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.is_read       (is_read),
		.cylinder      (cylinder),
		.tag           (tag),
		.res_ctl       (res_ctl),
		.res_ready     (res_ready),
		.res_tag       (res_tag),
		.res_is_read   (res_is_read),
		.res_cylinder  (res_cylinder),
		.res_occupancy (res_occupancy)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_ctl.valid) begin
			status_q <= res_ctl.status;
			tag_q    <= res_tag;
			rd_q     <= res_is_read;
			cyl_q    <= res_cylinder;
			occ_q    <= res_occupancy;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_tag      = tag_q;
	assign out_is_read  = rd_q;
	assign out_cylinder = cyl_q;
	assign occupancy    = occ_q;

endmodule

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = dsq_pkg::QUEUE_DEPTH_DEF;
	localparam int CYL_W      = dsq_pkg::CYLINDER_BITS_DEF;
	localparam int TAG_W      = dsq_pkg::TAG_BITS;
	localparam int OCC_W      = $clog2(DEPTH + 1);
	localparam int IDLE_LIMIT = 2000;
	localparam int SEG_ITEMS  = 25;
	localparam int SEG_COUNT  = 20;

	typedef struct {
		dsq_pkg::status_t  status;
		logic [TAG_W-1:0]  tag;
		logic              rd;
		logic [CYL_W-1:0]  cyl;
		logic [OCC_W-1:0]  occ;
	} seek_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                command;
	logic                is_read;
	logic [CYL_W-1:0]    cylinder;
	logic [TAG_W-1:0]    tag;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic [TAG_W-1:0]    out_tag;
	logic                out_is_read;
	logic [CYL_W-1:0]    out_cylinder;
	logic [OCC_W-1:0]    occupancy;

	// software copy of the request queue, head at index 0
	logic [CYL_W-1:0]    q_cyl [DEPTH];
	logic                q_rd  [DEPTH];
	logic [TAG_W-1:0]    q_tag [DEPTH];
	int                  q_count;

	seek_result_t pending_results[$];
	int  errors;
	int  idle_cycles;
	bit  steady;
	int  n_insert, n_remove, n_refused, n_empty, peak_occ;

	disk_request_seek_sort_queue_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.is_read     (is_read),
		.cylinder    (cylinder),
		.tag         (tag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_tag     (out_tag),
		.out_is_read (out_is_read),
		.out_cylinder(out_cylinder),
		.occupancy   (occupancy)
	);

	always #10 clk = ~clk;

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// seek-sort insert / head remove on the software queue
	function automatic seek_result_t apply_request(dsq_pkg::cmd_t cmd, logic rd,
			logic [CYL_W-1:0] cyl, logic [TAG_W-1:0] tg);
		seek_result_t r;
		bit found;
		bit stopped;
		int cand;
		int pos;
		int i;
		r.status = dsq_pkg::ST_DONE;
		r.tag    = '0;
		r.rd     = 1'b0;
		r.cyl    = '0;
		if (cmd == dsq_pkg::CMD_INSERT) begin
			if (q_count >= DEPTH) begin
				r.status = dsq_pkg::ST_FULL;
			end else begin
				found   = 1'b0;
				stopped = 1'b0;
				cand    = 0;
				for (i = 0; i < q_count; i++) begin
					if (!stopped) begin
						if (rd && !q_rd[i]) begin
							if (!found) begin
								found = 1'b1;
								cand  = i;
							end
							stopped = 1'b1;
						end else if (rd == q_rd[i] && q_cyl[i] <= cyl) begin
							if (!found || q_cyl[i] >= q_cyl[cand]) begin
								found = 1'b1;
								cand  = i;
							end
						end
					end
				end
				pos = found ? cand + 1 : q_count;
				for (i = q_count; i > pos; i--) begin
					q_cyl[i] = q_cyl[i-1];
					q_rd[i]  = q_rd[i-1];
					q_tag[i] = q_tag[i-1];
				end
				q_cyl[pos] = cyl;
				q_rd[pos]  = rd;
				q_tag[pos] = tg;
				q_count++;
			end
		end else begin
			if (q_count == 0) begin
				r.status = dsq_pkg::ST_EMPTY;
			end else begin
				r.tag = q_tag[0];
				r.rd  = q_rd[0];
				r.cyl = q_cyl[0];
				for (i = 1; i < q_count; i++) begin
					q_cyl[i-1] = q_cyl[i];
					q_rd[i-1]  = q_rd[i];
					q_tag[i-1] = q_tag[i];
				end
				q_count--;
			end
		end
		r.occ = q_count[OCC_W-1:0];
		return r;
	endfunction

	task automatic send_request(dsq_pkg::cmd_t cmd, logic rd, logic [CYL_W-1:0] cyl,
			logic [TAG_W-1:0] tg);
		int n;
		seek_result_t r;
		n = steady ? 0 : pause_len();
		if (n > 0) begin
			in_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid = 1'b1;
		command  = cmd;
		is_read  = rd;
		cylinder = cyl;
		tag      = tg;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = apply_request(cmd, rd, cyl, tg);
		pending_results.push_back(r);
		if (cmd == dsq_pkg::CMD_INSERT)
			n_insert++;
		else
			n_remove++;
		if (r.status == dsq_pkg::ST_FULL)
			n_refused++;
		if (r.status == dsq_pkg::ST_EMPTY)
			n_empty++;
		if (q_count > peak_occ)
			peak_occ = q_count;
		@(negedge clk);
	endtask

	task automatic test_empty_remove();
		send_request(dsq_pkg::CMD_REMOVE, 1'b1, 16'hffff, 8'hff);
	endtask

	// equal cylinders, extremes, reads stopping at the first write
	task automatic test_seek_order();
		send_request(dsq_pkg::CMD_INSERT, 1'b0, 16'd500,   8'h01);
		send_request(dsq_pkg::CMD_INSERT, 1'b0, 16'hffff,  8'hff);
		send_request(dsq_pkg::CMD_INSERT, 1'b0, 16'd0,     8'h00);
		send_request(dsq_pkg::CMD_INSERT, 1'b0, 16'd500,   8'h02);
		send_request(dsq_pkg::CMD_INSERT, 1'b1, 16'd100,   8'h10);
		send_request(dsq_pkg::CMD_INSERT, 1'b1, 16'd100,   8'h11);
		send_request(dsq_pkg::CMD_INSERT, 1'b1, 16'd0,     8'h12);
		send_request(dsq_pkg::CMD_INSERT, 1'b1, 16'hffff,  8'h13);
		send_request(dsq_pkg::CMD_INSERT, 1'b0, 16'd300,   8'h55);
	endtask

	task automatic test_full_queue();
		while (q_count < DEPTH)
			send_request(dsq_pkg::CMD_INSERT, 1'($urandom), 16'($urandom), 8'($urandom));
		send_request(dsq_pkg::CMD_INSERT, 1'b1, 16'haaaa, 8'haa);
		send_request(dsq_pkg::CMD_INSERT, 1'b0, 16'h5555, 8'h55);
	endtask

	task automatic test_random_traffic();
		int seg;
		int k;
		int ins_pct;
		int sel;
		logic [CYL_W-1:0] cyl;
		for (seg = 0; seg < SEG_COUNT; seg++) begin
			steady = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 4))
				0: ins_pct = 95;
				1: ins_pct = 80;
				2: ins_pct = 50;
				3: ins_pct = 20;
				default: ins_pct = 5;
			endcase
			for (k = 0; k < SEG_ITEMS; k++) begin
				sel = $urandom_range(0, 3);
				if (sel == 1)
					cyl = CYL_W'($urandom_range(0, 15));
				else if (sel == 2)
					cyl = $urandom_range(0, 1) ? '1 : '0;
				else
					cyl = CYL_W'($urandom);
				if ($urandom_range(0, 99) < ins_pct)
					send_request(dsq_pkg::CMD_INSERT, 1'($urandom), cyl, 8'($urandom));
				else
					send_request(dsq_pkg::CMD_REMOVE, 1'($urandom), cyl, 8'($urandom));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = dsq_pkg::CMD_INSERT;
		is_read   = 1'b0;
		cylinder  = '0;
		tag       = '0;
		q_count   = 0;
		errors    = 0;
		steady    = 1'b0;
		n_insert  = 0;
		n_remove  = 0;
		n_refused = 0;
		n_empty   = 0;
		peak_occ  = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_remove();
		test_seek_order();
		test_full_queue();
		test_random_traffic();
		in_valid = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d inserts (%0d refused on a full queue), %0d removes (%0d on empty)",
			n_insert, n_refused, n_remove, n_empty);
		$display("peak queue occupancy %0d of %0d", peak_occ, DEPTH);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// receiver stalls
	initial begin : rx_stall
		int n;
		out_ready = 1'b0;
		forever begin
			out_ready = 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			n = steady ? 0 : pause_len();
			if (n > 0) begin
				out_ready = 1'b0;
				repeat (n) @(negedge clk);
			end
		end
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		seek_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result transaction with none expected, %s %0d",
					$time, "expected none, actual status", status);
			end else begin
				want = pending_results.pop_front();
				check_field("status",       16'(want.status), 16'(status));
				check_field("out_tag",      16'(want.tag),    16'(out_tag));
				check_field("out_is_read",  16'(want.rd),     16'(out_is_read));
				check_field("out_cylinder", 16'(want.cyl),    16'(out_cylinder));
				check_field("occupancy",    16'(want.occ),    16'(occupancy));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial idle_cycles = 0;

endmodule

// ===== disk_request_seek_sort_queue_top.f =====
src/dsq_pkg.sv
src/dsq_ram.sv
src/dsq_core.sv
src/disk_request_seek_sort_queue_top.sv
dv/tb.sv
